// File: hdl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and constants for the sorted list with insert and delete.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_POS = 2'd2
  } status_e;

  typedef struct packed {
    logic        [ID_W-1:0]    id;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // command broadcast to every cell in the accepting cycle
  typedef struct packed {
    logic             insert;
    logic             delete;
    entry_t           new_entry;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
    logic [ID_W-1:0]        read_id;
    logic [VALUE_W-1:0]     read_value;
  } result_t;

endpackage

// File: hdl/slid_cell.sv
// ----------------------------------------------------------------------------
// slid_cell
// One slot of the sorted chain: keeps, shifts up, shifts down or takes a new
// entry, deciding from its own compare and its lower neighbour's.
// ----------------------------------------------------------------------------
module slid_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  slid_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                prev_up_i,
  input  slid_pkg::entry_t    prev_entry_i,
  input  slid_pkg::entry_t    next_entry_i,
  output slid_pkg::entry_t    entry_o,
  output logic                up_o
);
  import slid_pkg::*;

  localparam logic [POS_W:0] IdxCmp = (POS_W+1)'(IDX);

  entry_t entry_q;
  logic   gt;
  logic   at_or_after;

  assign gt          = entry_q.value > ctrl_i.new_entry.value;
  assign at_or_after = IdxCmp >= {1'b0, ctrl_i.pos};
  // this entry moves one place up on an insert
  assign up_o        = occ_i && gt;
  assign entry_o     = entry_q;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.insert) begin
      if (prev_up_i) begin
        entry_q <= prev_entry_i;
      end else if (!occ_i || gt) begin
        entry_q <= ctrl_i.new_entry;
      end
    end else if (ctrl_i.delete) begin
      if (at_or_after) begin
        entry_q <= next_entry_i;
      end
    end
  end

endmodule

// File: hdl/slid_outq.sv
// ----------------------------------------------------------------------------
// slid_outq
// Output register with a skid stage, so a word is taken while the previous
// result still waits downstream.
// ----------------------------------------------------------------------------
module slid_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  slid_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output slid_pkg::result_t out_data_o
);
  import slid_pkg::*;

  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push_i) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a word while the output register is empty");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("word pushed while the skid stage is occupied");
`endif

endmodule

// File: hdl/sorted_list_insert_delete.sv
// A result is registered in the output register, or in the skid stage while that one is held.
// Throughput: one word per cycle while in_stall_o is low; all cells compare and shift together.
// A stalled output is backed by a skid stage, so one more word is taken before in_stall_o rises.
// Reset clears the entry count and the output valid flags at once; the cells hold
// no reset value and are never read beyond the count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded list of (id, value) entries kept in ascending value order, built
// as a chain of cells with insert, delete at position and read at position.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
  parameter int unsigned CAPACITY = slid_pkg::DEF_CAPACITY
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [slid_pkg::KIND_W-1:0]     kind_i,
  input  logic        [slid_pkg::ID_W-1:0]       entry_id_i,
  input  logic signed [slid_pkg::VALUE_W-1:0]    entry_value_i,
  input  logic        [slid_pkg::POS_W-1:0]      position_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [slid_pkg::STATUS_W-1:0]   status_o,
  output logic        [slid_pkg::COUNT_OUT_W-1:0] entry_count_o,
  output logic        [slid_pkg::ID_W-1:0]       read_id_o,
  output logic signed [slid_pkg::VALUE_W-1:0]    read_value_o
);
  import slid_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic            accept;
  logic            full;
  logic            pos_ok;
  logic            q_full;
  cell_ctrl_t      ctrl;
  entry_t          rd_entry;
  result_t         res;
  result_t         out_data;
  entry_t          entries [CAPACITY];
  logic            up      [CAPACITY];
  logic            occ     [CAPACITY];

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;
  assign pos_ext    = CmpW'(position_i);
  assign cnt_ext    = CmpW'(count_q);
  assign full       = count_q == CntW'(CAPACITY);
  assign pos_ok     = pos_ext < cnt_ext;

  always_comb begin
    ctrl                 = '0;
    ctrl.new_entry.id    = entry_id_i;
    ctrl.new_entry.value = entry_value_i;
    ctrl.pos             = position_i;
    ctrl.insert          = accept && (kind_i == KIND_INSERT) && !full;
    ctrl.delete          = accept && (kind_i == KIND_DELETE) && pos_ok;
  end

  // occupancy as a thermometer of the count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = CmpW'(i) < cnt_ext;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_u;

    if (g == 0) begin : g_first
      assign prev_e = '0;
      assign prev_u = 1'b0;
    end else begin : g_mid
      assign prev_e = entries[g-1];
      assign prev_u = up[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_e = entries[g];
    end else begin : g_body
      assign next_e = entries[g+1];
    end

    slid_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[g]),
      .prev_up_i    (prev_u),
      .prev_entry_i (prev_e),
      .next_entry_i (next_e),
      .entry_o      (entries[g]),
      .up_o         (up[g])
    );
  end

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_ext == CmpW'(i)) begin
        rd_entry = entries[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.delete) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    res            = '0;
    res.status     = ST_DONE;
    res.count      = COUNT_OUT_W'(count_d);
    unique case (kind_i)
      KIND_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end
      end
      KIND_DELETE: begin
        if (!pos_ok) begin
          res.status = ST_NO_POS;
        end
      end
      KIND_READ: begin
        if (pos_ok) begin
          res.read_id    = rd_entry.id;
          res.read_value = rd_entry.value;
        end else begin
          res.status = ST_NO_POS;
        end
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  slid_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign status_o      = out_data.status;
  assign entry_count_o = out_data.count;
  assign read_id_o     = out_data.read_id;
  assign read_value_o  = out_data.read_value;

`ifndef SYNTHESIS
  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not raise the count");

  a_delete_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.delete |=> count_q == $past(count_q) - 1'b1)
    else $error("delete did not lower the count");

  a_idle_count_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> count_q == $past(count_q))
    else $error("count changed without an accepted word");
`endif

endmodule
